// ===== rtl/core/pidc_pkg.sv =====
// Shared types and constants for the clamped PID controller.
`default_nettype none
package pidc_pkg;
	localparam int unsigned DataW = 32;
	localparam int unsigned FracW = 16;
	localparam int unsigned AddrW = 5;
	localparam int unsigned MulW  = 33;
	localparam int unsigned ProdW = 2 * MulW;
	localparam int unsigned NumW  = DataW + 1 + FracW;
	localparam int unsigned TermW = ProdW + 1 - FracW;
	localparam int unsigned TotW  = TermW + 2;
	localparam int unsigned CntW  = 6;

	localparam logic [2:0] REG_GAIN_P = 3'd0;
	localparam logic [2:0] REG_GAIN_I = 3'd1;
	localparam logic [2:0] REG_GAIN_D = 3'd2;
	localparam logic [2:0] REG_LIMIT  = 3'd3;
	localparam logic [2:0] REG_STEP_MIN = 3'd4;
	localparam logic [2:0] REG_STEP_MAX = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_INT, ST_INT, ST_DIV, ST_DSAT,
		ST_MUL_P, ST_ADD_P, ST_MUL_I, ST_ADD_I, ST_MUL_D, ST_ADD_D, ST_FIN
	} pidc_state_t;
endpackage
`default_nettype wire

// ===== rtl/core/pid_controller_clamped.sv =====
// Top level of the clamped PID controller: sequencer, bit-serial multiplier and divider.
`default_nettype none
// One transaction on the input channel yields one transaction on the result channel.
// The time step is clamped to [step_min, step_max] (a zero step becomes 1 LSB), the
// error times the step is added to the clamped integral, the derivative is the change
// in error over the step, and the drive is the saturated sum of three gain terms.
// All arithmetic runs through one shift-add multiplier (one bit per cycle) and one
// restoring divider (one quotient bit per cycle). An item passes through the integral
// product and update, the derivative division and saturation, and the three gain
// products and sums before it reaches the result register; a new transaction is taken
// in the cycle after the result is loaded, while that result may still wait for ready.
// Registers are written through the APB port at byte address 4*index.
module pid_controller_clamped (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                valid,
	output logic                     ready,
	input  wire logic signed [31:0]  error_in,
	input  wire logic [31:0]         step_time,
	input  wire logic                clear_first,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output logic signed [31:0]       drive,
	output logic                     saturated
);
	import pidc_pkg::*;

	// configuration
	logic [DataW-1:0] gp_q, gi_q, gd_q, smin_q, smax_q;
	logic [DataW-2:0] lim_q;
	logic             wr_en;
	logic [2:0]       reg_idx;

	// sequencer and working registers
	pidc_state_t      state_q, state_d;
	logic [CntW-1:0]  cnt_q;
	logic [DataW-1:0] err_q, step_q, integ_q, last_q, deriv_q;
	logic             hit_q;
	logic signed [TotW-1:0] tot_q;

	// multiplier
	logic [MulW-1:0]  mul_a_q;
	logic [ProdW-1:0] mul_p_q;
	logic             mul_neg_q;
	logic [MulW:0]    mul_sum;
	logic signed [ProdW:0] prod;
	logic signed [TermW-1:0] term;

	// divider
	logic [DataW-1:0] rem_q;
	logic [NumW-1:0]  quo_q;
	logic             div_neg_q;
	logic [DataW:0]   div_t;
	logic [DataW+1:0] div_diff;

	// misc datapath
	logic [DataW-1:0] s_lo, s_hi, s_clamp;
	logic signed [TermW+1:0] acc_new, lim_pos, lim_neg;
	logic signed [DataW:0]   diff;
	logic [DataW:0]   diff_mag;
	logic             mul_last, div_last, out_load;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			REG_GAIN_P:   prdata = gp_q;
			REG_GAIN_I:   prdata = gi_q;
			REG_GAIN_D:   prdata = gd_q;
			REG_LIMIT:    prdata = {1'b0, lim_q};
			REG_STEP_MIN: prdata = smin_q;
			REG_STEP_MAX: prdata = smax_q;
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q   <= 32'd39322;
			gi_q   <= 32'd3277;
			gd_q   <= 32'd6554;
			lim_q  <= 31'd6553600;
			smin_q <= 32'd66;
			smax_q <= 32'd6554;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAIN_P:   gp_q   <= pwdata;
				REG_GAIN_I:   gi_q   <= pwdata;
				REG_GAIN_D:   gd_q   <= pwdata;
				REG_LIMIT:    lim_q  <= pwdata[DataW-2:0];
				REG_STEP_MIN: smin_q <= pwdata;
				REG_STEP_MAX: smax_q <= pwdata;
				default: ;
			endcase
		end
	end

	// step window; upper clamp last, zero becomes one LSB
	assign s_lo    = (step_time < smin_q) ? smin_q : step_time;
	assign s_hi    = (s_lo > smax_q) ? smax_q : s_lo;
	assign s_clamp = (s_hi == '0) ? DataW'(1) : s_hi;

	// shift-add step: low half holds the remaining multiplier bits
	assign mul_sum = mul_p_q[0] ? ({1'b0, mul_p_q[ProdW-1:MulW]} + {1'b0, mul_a_q})
	                            : {1'b0, mul_p_q[ProdW-1:MulW]};
	assign prod    = mul_neg_q ? -$signed({1'b0, mul_p_q}) : $signed({1'b0, mul_p_q});
	// round half up then drop the fraction
	assign term    = TermW'((prod + (ProdW+1)'(32768)) >>> FracW);

	assign div_t    = {rem_q, quo_q[NumW-1]};
	assign div_diff = {1'b0, div_t} - {2'b00, step_q};

	assign acc_new = (TermW+2)'($signed(integ_q)) + (TermW+2)'(term);
	assign lim_pos = (TermW+2)'($signed({1'b0, lim_q}));
	assign lim_neg = -lim_pos;
	assign diff    = $signed({err_q[DataW-1], err_q}) - $signed({last_q[DataW-1], last_q});
	assign diff_mag = diff[DataW] ? DataW'(0) - diff : diff;

	assign mul_last = (cnt_q == CntW'(MulW - 1));
	assign div_last = (cnt_q == CntW'(NumW - 1));
	assign out_load = (state_q == ST_FIN) && (!res_valid || res_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (valid) state_d = ST_MUL_INT;
			ST_MUL_INT: if (mul_last) state_d = ST_INT;
			ST_INT:     state_d = ST_DIV;
			ST_DIV:     if (div_last) state_d = ST_DSAT;
			ST_DSAT:    state_d = ST_MUL_P;
			ST_MUL_P:   if (mul_last) state_d = ST_ADD_P;
			ST_ADD_P:   state_d = ST_MUL_I;
			ST_MUL_I:   if (mul_last) state_d = ST_ADD_I;
			ST_ADD_I:   state_d = ST_MUL_D;
			ST_MUL_D:   if (mul_last) state_d = ST_ADD_D;
			ST_ADD_D:   state_d = ST_FIN;
			ST_FIN:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready = (state_q == ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			integ_q   <= '0;
			last_q    <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL_INT || state_q == ST_DIV || state_q == ST_MUL_P
			    || state_q == ST_MUL_I || state_q == ST_MUL_D) begin
				cnt_q <= (state_d == state_q) ? cnt_q + CntW'(1) : '0;
			end else begin
				cnt_q <= '0;
			end
			if (ready && valid && clear_first) begin
				integ_q <= '0;
				last_q  <= '0;
			end
			if (state_q == ST_INT) begin
				if (acc_new > lim_pos)      integ_q <= DataW'(lim_pos);
				else if (acc_new < lim_neg) integ_q <= DataW'(lim_neg);
				else                        integ_q <= DataW'(acc_new);
			end
			if (out_load) begin
				last_q    <= err_q;
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// operand loads for the shared multiplier and the divider, divider steps and term sums
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				err_q     <= error_in;
				step_q    <= s_clamp;
				mul_a_q   <= error_in[DataW-1] ? MulW'(0) - {1'b1, error_in}
				                               : {1'b0, error_in};
				mul_p_q   <= {{MulW{1'b0}}, 1'b0, s_clamp};
				mul_neg_q <= error_in[DataW-1];
			end
			ST_INT: begin
				rem_q     <= '0;
				quo_q     <= {diff_mag, {FracW{1'b0}}};
				div_neg_q <= diff[DataW];
			end
			ST_DIV: begin
				if (!div_diff[DataW+1]) begin
					rem_q <= div_diff[DataW-1:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= div_t[DataW-1:0];
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
			end
			ST_DSAT: begin
				hit_q <= 1'b0;
				if (div_neg_q) begin
					if (quo_q > NumW'(33'h080000000)) begin
						deriv_q <= 32'h80000000;
						hit_q   <= 1'b1;
					end else begin
						deriv_q <= DataW'(0) - quo_q[DataW-1:0];
					end
				end else if (quo_q > NumW'(32'h7fffffff)) begin
					deriv_q <= 32'h7fffffff;
					hit_q   <= 1'b1;
				end else begin
					deriv_q <= quo_q[DataW-1:0];
				end
				tot_q     <= '0;
				mul_a_q   <= gp_q[DataW-1] ? MulW'(0) - {1'b1, gp_q} : {1'b0, gp_q};
				mul_p_q   <= {{MulW{1'b0}}, err_q[DataW-1] ? MulW'(0) - {1'b1, err_q}
				                                           : {1'b0, err_q}};
				mul_neg_q <= gp_q[DataW-1] ^ err_q[DataW-1];
			end
			ST_ADD_P: begin
				tot_q     <= tot_q + TotW'(term);
				mul_a_q   <= gi_q[DataW-1] ? MulW'(0) - {1'b1, gi_q} : {1'b0, gi_q};
				mul_p_q   <= {{MulW{1'b0}}, integ_q[DataW-1] ? MulW'(0) - {1'b1, integ_q}
				                                             : {1'b0, integ_q}};
				mul_neg_q <= gi_q[DataW-1] ^ integ_q[DataW-1];
			end
			ST_ADD_I: begin
				tot_q     <= tot_q + TotW'(term);
				mul_a_q   <= gd_q[DataW-1] ? MulW'(0) - {1'b1, gd_q} : {1'b0, gd_q};
				mul_p_q   <= {{MulW{1'b0}}, deriv_q[DataW-1] ? MulW'(0) - {1'b1, deriv_q}
				                                             : {1'b0, deriv_q}};
				mul_neg_q <= gd_q[DataW-1] ^ deriv_q[DataW-1];
			end
			ST_ADD_D: tot_q <= tot_q + TotW'(term);
			ST_MUL_INT, ST_MUL_P, ST_MUL_I, ST_MUL_D:
				mul_p_q <= {mul_sum, mul_p_q[MulW-1:1]};
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (tot_q > TotW'(32'sh7fffffff)) begin
				drive     <= 32'h7fffffff;
				saturated <= 1'b1;
			end else if (tot_q < -TotW'(33'sh080000000)) begin
				drive     <= 32'h80000000;
				saturated <= 1'b1;
			end else begin
				drive     <= DataW'(tot_q);
				saturated <= hit_q;
			end
		end
	end

	// input is taken only in the idle state, and the sequencer leaves it right after
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready) |=> (state_q == ST_MUL_INT))
		else $error("sequencer did not start after input transaction");
	// divisor is never zero while dividing
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q != '0))
		else $error("zero divisor in derivative");
	// a result appears only as the sequencer finishes
	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> ($past(state_q) == ST_FIN))
		else $error("result without finished item");
endmodule
`default_nettype wire
